/* hw/rtl/tma_pkg.sv */
// ----------------------------------------------------------------------------
// tma_pkg
// Shared types and constants for the transposed matrix-vector accumulator.
// ----------------------------------------------------------------------------
package tma_pkg;

  localparam int ROWS_W       = 16;
  localparam int COLS_W       = 7;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int COL_IDX_W    = 6;
  localparam int PROD_W       = 32;
  localparam int ACC_W        = 48;
  localparam int RES_W        = 32;
  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_Q_DEPTH  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b1;

  typedef struct packed {
    logic signed [15:0] weight;
    logic signed [15:0] grad;
  } in_item_t;

  typedef struct packed {
    logic [COL_IDX_W-1:0]   column_index;
    logic signed [RES_W-1:0] result;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic first_row;
    logic last_row;
    logic last_col;
  } op_flags_t;

endpackage

/* hw/rtl/tma_ram.sv */
// ----------------------------------------------------------------------------
// tma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/tma_queue.sv */
// ----------------------------------------------------------------------------
// tma_queue
// Small register-based FIFO with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module tma_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/tma_front.sv */
// ----------------------------------------------------------------------------
// tma_front
// Configuration registers and row/column tracking; tags each accepted request
// with its column and row position.
// ----------------------------------------------------------------------------
module tma_front
  import tma_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  accept,
  output logic [CW-1:0]         op_col,
  output op_flags_t             op_flags
);

  localparam int EW = (CW + 1 > COLS_W) ? CW + 1 : COLS_W;

  logic [ROWS_W-1:0] rows_r;
  logic [COLS_W-1:0] cols_r;
  logic [CW-1:0]     col_r, col_nxt;
  logic [ROWS_W-1:0] row_r, row_nxt;
  logic [EW-1:0]     cols_ext, cols_eff;
  logic [ROWS_W-1:0] rows_eff;
  logic [CW-1:0]     col_cur;
  logic              last_col, last_row;

  always_comb begin
    cols_ext = EW'(cols_r);
    if (cols_ext == '0) begin
      cols_eff = EW'(1);
    end else if (cols_ext > EW'(MAX_COLS)) begin
      cols_eff = EW'(MAX_COLS);
    end else begin
      cols_eff = cols_ext;
    end
    rows_eff = (rows_r == '0) ? ROWS_W'(1) : rows_r;
    col_cur  = (EW'(col_r) >= EW'(MAX_COLS)) ? CW'(MAX_COLS - 1) : col_r;
    last_col = ((EW'(col_cur) + EW'(1)) >= cols_eff);
    last_row = (({1'b0, row_r} + 17'd1) >= {1'b0, rows_eff});
  end

  assign op_col             = col_cur;
  assign op_flags.first_row = (row_r == '0);
  assign op_flags.last_row  = last_row;
  assign op_flags.last_col  = last_col;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_W'(1);
      cols_r <= COLS_W'(1);
      col_r  <= '0;
      row_r  <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROWS_IN_USE: rows_r <= cfg_wdata[ROWS_W-1:0];
          CFG_COLS_IN_USE: cols_r <= cfg_wdata[COLS_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* hw/rtl/tma_back.sv */
// ----------------------------------------------------------------------------
// tma_back
// Multiply, accumulate into the per-column RAM, round and saturate, and hand
// finished requests to the output queue.
// ----------------------------------------------------------------------------
module tma_back
  import tma_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          op_empty,
  input  in_item_t      op_item,
  input  logic [CW-1:0] op_col,
  input  op_flags_t     op_flags,
  output logic          op_pop,
  input  logic          res_full,
  output logic          res_push,
  output out_item_t     res_item
);

  logic                     adv;
  logic                     b_valid_r, b_valid_nxt;
  logic [CW-1:0]            b_col_r;
  op_flags_t                b_flags_r;
  logic signed [PROD_W-1:0] b_prod_r;
  logic                     c_valid_r, c_valid_nxt;
  logic [CW-1:0]            c_col_r;
  logic                     c_last_r;
  logic signed [ACC_W-1:0]  c_sum_r;
  logic                     lw_valid_r;
  logic [CW-1:0]            lw_col_r;
  logic signed [ACC_W-1:0]  lw_sum_r;
  logic [ACC_W-1:0]         ram_rdata;
  logic signed [ACC_W-1:0]  acc_in, b_sum;
  logic                     ram_we;
  logic signed [ACC_W:0]    rnd;
  logic signed [ACC_W-12:0] quo;
  logic signed [RES_W-1:0]  sat;
  logic [CW+COL_IDX_W-1:0]  col_ext;

  assign adv    = !res_full;
  assign op_pop = adv && !op_empty;
  assign ram_we = adv && b_valid_r;

  tma_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_COLS),
    .AW    (CW)
  ) u_acc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (b_col_r),
    .wdata (b_sum),
    .re    (op_pop),
    .raddr (op_col),
    .rdata (ram_rdata)
  );

  always_comb begin
    acc_in = (lw_valid_r && (lw_col_r == b_col_r)) ? lw_sum_r : $signed(ram_rdata);
    if (b_flags_r.first_row) begin
      b_sum = ACC_W'(b_prod_r);
    end else begin
      b_sum = acc_in + ACC_W'(b_prod_r);
    end
  end

  always_comb begin
    rnd = (ACC_W + 1)'(c_sum_r) + (ACC_W + 1)'(2048);
    quo = rnd[ACC_W:12];
    if (quo > (ACC_W - 11)'(32'sh7fff_ffff)) begin
      sat = {1'b0, {(RES_W - 1){1'b1}}};
    end else if (quo < -(ACC_W - 11)'(33'sh0_8000_0000)) begin
      sat = {1'b1, {(RES_W - 1){1'b0}}};
    end else begin
      sat = quo[RES_W-1:0];
    end
    col_ext = {{COL_IDX_W{1'b0}}, c_col_r};
  end

  assign res_push              = adv && c_valid_r;
  assign res_item.column_index = col_ext[COL_IDX_W-1:0];
  assign res_item.result       = sat;
  assign res_item.last         = c_last_r;

  always_comb begin
    b_valid_nxt = b_valid_r;
    c_valid_nxt = c_valid_r;
    if (adv) begin
      b_valid_nxt = !op_empty;
      c_valid_nxt = b_valid_r && b_flags_r.last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r  <= 1'b0;
      c_valid_r  <= 1'b0;
      lw_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
      c_valid_r <= c_valid_nxt;
      if (ram_we) begin
        lw_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      b_col_r   <= op_col;
      b_flags_r <= op_flags;
      b_prod_r  <= PROD_W'(op_item.weight * op_item.grad);
    end
    if (adv) begin
      c_col_r  <= b_col_r;
      c_last_r <= b_flags_r.last_col;
      c_sum_r  <= b_sum;
    end
    if (ram_we) begin
      lw_col_r <= b_col_r;
      lw_sum_r <= b_sum;
    end
  end

endmodule

/* hw/rtl/transposed_matvec_accumulate.sv */
// ----------------------------------------------------------------------------
// transposed_matvec_accumulate
// dx = transpose(W) * dy over a row-major weight stream with per-column
// accumulators; emits rounded, saturated Q20.12 dx on the last row.
// A request passes the operand queue, the product and sum registers and the result queue.
// Throughput: one request per cycle unless the result queue is full, set by
// the one-write, one-read accumulator RAM and single-entry write-forward path.
// Reset: counters cleared, rows_in_use and cols_in_use set to 1, queues
// emptied; the accumulator RAM is not cleared, the first row overwrites it.
// ----------------------------------------------------------------------------
module transposed_matvec_accumulate
  import tma_pkg::*;
#(
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int QUEUE_DEPTH = DEF_Q_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  in_item_t              in_item,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int IW  = $bits(in_item_t);
  localparam int FW  = $bits(op_flags_t);
  localparam int OPW = IW + FW + CW;
  localparam int RW  = $bits(out_item_t);

  logic            accept;
  logic [CW-1:0]   f_col;
  op_flags_t       f_flags;
  logic [OPW-1:0]  op_wdata, op_rdata;
  logic            op_full, op_empty, op_pop;
  in_item_t        op_item;
  logic [CW-1:0]   op_col;
  op_flags_t       op_flags;
  logic            res_full, res_push;
  out_item_t       res_item;
  logic [RW-1:0]   res_rdata;

  assign accept  = in_push && !op_full;
  assign in_full = op_full;

  tma_front #(
    .MAX_COLS (MAX_COLS),
    .CW       (CW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .op_col    (f_col),
    .op_flags  (f_flags)
  );

  assign op_wdata = {in_item, f_flags, f_col};

  tma_queue #(
    .WIDTH (OPW),
    .DEPTH (QUEUE_DEPTH)
  ) u_op_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (op_wdata),
    .full      (op_full),
    .pop       (op_pop),
    .head_data (op_rdata),
    .empty     (op_empty)
  );

  assign op_item  = op_rdata[OPW-1 -: IW];
  assign op_flags = op_rdata[CW+FW-1 -: FW];
  assign op_col   = op_rdata[CW-1:0];

  tma_back #(
    .MAX_COLS (MAX_COLS),
    .CW       (CW)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_empty (op_empty),
    .op_item  (op_item),
    .op_col   (op_col),
    .op_flags (op_flags),
    .op_pop   (op_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_item (res_item)
  );

  tma_queue #(
    .WIDTH (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_item),
    .full      (res_full),
    .pop       (out_pop),
    .head_data (res_rdata),
    .empty     (out_empty)
  );

  assign out_item = res_rdata;

endmodule

/* tb/sv/tb_transposed_matvec_accumulate.sv */
// ----------------------------------------------------------------------------
// tb_transposed_matvec_accumulate
// Streams weight/grad requests through the block and checks every dx result
// against an in-bench predictor of the per-column accumulators. Covers field
// extremes, rounding ties, out-of-range sizes, mid-vector resizing, long
// accumulations, back-pressure and randomized matrix shapes with random idling.
// ----------------------------------------------------------------------------
module tb_transposed_matvec_accumulate
  import tma_pkg::*;
();

  localparam int NUM_COLS     = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 600;

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  in_item_t              in_item;
  logic                  out_empty;
  logic                  out_pop;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  logic signed [ACC_W-1:0] col_acc [NUM_COLS];
  logic [5:0]              col_pos;
  logic [15:0]             row_pos;
  logic [15:0]             rows_cfg;
  logic [6:0]              cols_cfg;
  out_item_t               dx_expected [$];

  int fail_count;
  int sink_hold;
  bit src_idle;
  bit sink_idle;

  transposed_matvec_accumulate uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [RES_W-1:0] round_to_q20(longint acc);
    longint q;
    q = (acc + 2048) >>> 12;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[RES_W-1:0];
  endfunction

  function automatic void predict_dx(in_item_t req);
    longint    prod;
    longint    acc;
    int        eff_cols;
    int        eff_rows;
    int        col;
    bit        last_col;
    bit        last_row;
    out_item_t dx;
    prod     = longint'($signed(req.weight)) * longint'($signed(req.grad));
    eff_cols = (cols_cfg == 0) ? 1 : ((cols_cfg > NUM_COLS) ? NUM_COLS : int'(cols_cfg));
    eff_rows = (rows_cfg == 0) ? 1 : int'(rows_cfg);
    col      = int'(col_pos);
    last_col = (col + 1 >= eff_cols);
    last_row = (int'(row_pos) + 1 >= eff_rows);
    acc = (row_pos == 0) ? prod : longint'(col_acc[col]) + prod;
    col_acc[col] = acc[ACC_W-1:0];
    if (last_row) begin
      dx.column_index = col[5:0];
      dx.result       = round_to_q20(longint'(col_acc[col]));
      dx.last         = last_col;
      dx_expected.push_back(dx);
    end
    if (last_col) begin
      col_pos = '0;
      row_pos = last_row ? 16'd0 : row_pos + 16'd1;
    end else begin
      col_pos = col_pos + 6'd1;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (!src_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'hffff;
          default: return 16'h0001;
        endcase
      end
      1: return 16'($urandom_range(0, 63)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_request(in_item_t req);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_push <= 1'b0;
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (in_full);
    predict_dx(req);
  endtask

  task automatic send_wg(logic [15:0] w, logic [15:0] g);
    in_item_t req;
    req.weight = w;
    req.grad   = g;
    send_request(req);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_push <= 1'b0;
    while (dx_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ROWS_IN_USE) rows_cfg = data[15:0];
    else cols_cfg = data[6:0];
  endtask

  task automatic set_shape(logic [15:0] rows_raw, logic [15:0] cols_raw);
    write_reg(CFG_ROWS_IN_USE, rows_raw);
    write_reg(CFG_COLS_IN_USE, cols_raw);
  endtask

  task automatic test_field_extremes();
    drain_results();
    set_shape(16'd1, 16'd4);
    send_wg(16'h8000, 16'h8000);
    send_wg(16'h8000, 16'h7fff);
    send_wg(16'h7fff, 16'h7fff);
    send_wg(16'h7fff, 16'h8000);
    // rounding ties, both signs
    send_wg(16'h0001, 16'd2048);
    send_wg(16'hffff, 16'd2048);
    send_wg(16'h0003, 16'd2048);
    send_wg(16'hfffd, 16'd2048);
    send_wg(16'h0000, 16'h8000);
    send_wg(16'hffff, 16'hffff);
    send_wg(16'h0001, 16'h0001);
    send_wg(16'h5555, 16'haaaa);
    drain_results();
    set_shape(16'd2, 16'd3);
    send_wg(16'h7fff, 16'h7fff);
    send_wg(16'h8000, 16'h7fff);
    send_wg(16'h1234, 16'h7fff);
    send_wg(16'h7fff, 16'h8000);
    send_wg(16'h8000, 16'h8000);
    send_wg(16'hedcc, 16'h8000);
  endtask

  task automatic test_size_corners();
    drain_results();
    set_shape(16'd0, 16'd0);
    repeat (3) send_wg(rand_field(), rand_field());
    drain_results();
    set_shape(16'd1, 16'hffff);
    repeat (NUM_COLS) send_wg(rand_field(), rand_field());
    // shrink rows and columns in the middle of a vector
    drain_results();
    set_shape(16'd3, 16'd4);
    repeat (6) send_wg(rand_field(), rand_field());
    drain_results();
    set_shape(16'd2, 16'd2);
    send_wg(rand_field(), rand_field());
    drain_results();
    set_shape(16'd4, 16'd1);
    repeat (3) send_wg(rand_field(), rand_field());
    drain_results();
    set_shape(16'd2, 16'd1);
    send_wg(rand_field(), rand_field());
  endtask

  task automatic test_long_rows();
    drain_results();
    src_idle = 1'b0;
    set_shape(16'd150, 16'd1);
    repeat (150) send_wg(16'h8000, 16'h8000);
    drain_results();
    set_shape(16'd140, 16'd1);
    repeat (140) send_wg(16'h8000, 16'h7fff);
    drain_results();
    src_idle = 1'b1;
  endtask

  task automatic test_backpressure();
    drain_results();
    set_shape(16'd1, 16'd8);
    src_idle  = 1'b0;
    sink_hold = 60;
    repeat (40) send_wg(rand_field(), rand_field());
    drain_results();
    src_idle = 1'b1;
  endtask

  task automatic test_random_streams();
    int         sent;
    int         nrows;
    int         ncols;
    int         eff_rows;
    int         eff_cols;
    int         nvec;
    logic [15:0] rows_raw;
    logic [15:0] cols_raw;
    logic [15:0] g;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      case ($urandom_range(0, 19))
        0, 1: nrows = 0;
        2, 3, 4, 5, 6, 7, 8, 9, 10: nrows = 1;
        11, 12, 13, 14, 15, 16: nrows = $urandom_range(2, 4);
        default: nrows = $urandom_range(5, 16);
      endcase
      case ($urandom_range(0, 19))
        0, 1: ncols = 0;
        2, 3: ncols = NUM_COLS;
        4, 5, 6: ncols = $urandom_range(65, 127);
        7, 8, 9, 10, 11: ncols = $urandom_range(9, 63);
        default: ncols = $urandom_range(1, 8);
      endcase
      if (nrows > 4 && ncols > 8) ncols = $urandom_range(1, 8);
      rows_raw = 16'(nrows);
      cols_raw = 16'(ncols);
      if ($urandom_range(0, 3) == 0) cols_raw[15:7] = 9'($urandom);
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_COLS_IN_USE, cols_raw);
        write_reg(CFG_ROWS_IN_USE, rows_raw);
      end else begin
        set_shape(rows_raw, cols_raw);
      end
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      eff_rows = (nrows == 0) ? 1 : nrows;
      eff_cols = (ncols == 0) ? 1 : ((ncols > NUM_COLS) ? NUM_COLS : ncols);
      nvec = $urandom_range(40, 120) / (eff_rows * eff_cols);
      if (nvec == 0) nvec = 1;
      repeat (nvec) begin
        repeat (eff_rows) begin
          g = rand_field();
          repeat (eff_cols) begin
            send_wg(rand_field(), ($urandom_range(0, 9) == 0) ? rand_field() : g);
            sent++;
          end
        end
        if ($urandom_range(0, 7) == 0) drain_results();
      end
    end
  endtask

  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_pop <= 1'b0;
        sink_hold--;
      end else if (sink_idle && $urandom_range(0, 99) < 20) begin
        out_pop <= 1'b0;
        sink_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : dx_check
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (dx_expected.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected dx: column %0d result %0d last %0b",
                   out_item.column_index, out_item.result, out_item.last);
      end else begin
        want = dx_expected.pop_front();
        if (want.column_index !== out_item.column_index || want.result !== out_item.result ||
            want.last !== out_item.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("dx mismatch: column exp %0d got %0d, result exp %0d got %0d, last exp %0b got %0b",
                     want.column_index, out_item.column_index, want.result, out_item.result,
                     want.last, out_item.last);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_push    = 1'b0;
    in_item    = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_ROWS_IN_USE;
    cfg_wdata  = '0;
    fail_count = 0;
    sink_hold  = 0;
    src_idle   = 1'b1;
    sink_idle  = 1'b1;
    rows_cfg   = 16'd1;
    cols_cfg   = 7'd1;
    col_pos    = '0;
    row_pos    = '0;
    foreach (col_acc[i]) col_acc[i] = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_size_corners();
    test_backpressure();
    test_long_rows();
    test_random_streams();
    drain_results();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
